// ===== rtl/i2crts_pkg.sv =====
// shared types and constants of the i2c register transaction sequencer
package i2crts_pkg;

	localparam int HEADER_DEPTH_DEF = 8;
	localparam int DATA_DEPTH_DEF = 64;

	typedef struct packed {
		logic [6:0] dev;
		logic [7:0] sub;
		logic       is_read;
		logic [7:0] len;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

endpackage

// ===== rtl/i2crts_queue.sv =====
// circular queue in a synchronous memory with a registered head read
module i2crts_queue #(
	parameter int W = i2crts_pkg::HDR_W,
	parameter int DEPTH = i2crts_pkg::HEADER_DEPTH_DEF,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  i2crts_pkg::q_ctl_t  ctl,
	input  logic [W-1:0]        wdata,
	output logic [W-1:0]        rdata,
	output logic [CNT_W-1:0]    count
);

	logic [W-1:0]     mem_q [DEPTH];
	logic [W-1:0]     rdata_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
		rdata_q <= mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (ctl.pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({ctl.push, ctl.pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign rdata = rdata_q;
	assign count = count_q;

endmodule

// ===== rtl/i2crts_seq.sv =====
// transaction intake, bus command state machine and result register
module i2crts_seq #(
	parameter int HEADER_DEPTH = i2crts_pkg::HEADER_DEPTH_DEF,
	parameter int DATA_DEPTH = i2crts_pkg::DATA_DEPTH_DEF,
	localparam int HC_W = $clog2(HEADER_DEPTH + 1),
	localparam int DC_W = $clog2(DATA_DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [1:0]                  func,
	input  logic [6:0]                  dev_addr,
	input  logic [7:0]                  reg_addr,
	input  logic                        is_read,
	input  logic [7:0]                  length,
	input  logic [7:0]                  write_byte,
	input  logic [7:0]                  received_byte,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [2:0]                  bus_command,
	output logic [7:0]                  tx_byte,
	output logic                        read_valid,
	output logic [7:0]                  read_byte,
	output logic                        read_done,
	output logic [6:0]                  done_dev_addr,
	output logic [7:0]                  done_reg_addr,
	output logic [1:0]                  status,
	output logic                        bus_idle,
	output i2crts_pkg::q_ctl_t          hq_ctl,
	output logic [i2crts_pkg::HDR_W-1:0] hq_wdata,
	input  logic [i2crts_pkg::HDR_W-1:0] hq_rdata,
	input  logic [HC_W-1:0]             hq_count,
	output i2crts_pkg::q_ctl_t          dq_ctl,
	output logic [7:0]                  dq_wdata,
	input  logic [7:0]                  dq_rdata,
	input  logic [DC_W-1:0]             dq_count
);

	localparam int SUM_W = ((DC_W > 8) ? DC_W : 8) + 1;

	typedef enum logic [3:0] {
		PH_STOPPED = 4'd0,
		PH_STARTED = 4'd1,
		PH_ADDR_W  = 4'd2,
		PH_SUB     = 4'd3,
		PH_DATA_TX = 4'd4,
		PH_RESTART = 4'd5,
		PH_ADDR_R  = 4'd6,
		PH_DATA_RX = 4'd7,
		PH_ACK     = 4'd8,
		PH_NACK    = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_TX      = 3'd2,
		CMD_RESTART = 3'd3,
		CMD_RX      = 3'd4,
		CMD_ACK     = 3'd5,
		CMD_NACK    = 3'd6,
		CMD_STOP    = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		FN_HDR  = 2'd0,
		FN_DATA = 2'd1,
		FN_BUS  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DROPPED = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

	// item stage
	logic       valid_s1;
	logic [1:0] func_s1;
	logic [6:0] dev_s1;
	logic [7:0] sub_s1;
	logic       rd_s1;
	logic [7:0] len_s1;
	logic [7:0] wb_s1;
	logic [7:0] rb_s1;

	// sequencer state
	phase_t            phase_q, phase_n;
	logic              idle_q, idle_n;
	i2crts_pkg::hdr_t  hdr_q, hdr_n;
	logic [7:0]        bc_q, bc_n;
	logic [7:0]        wbp_q, wbp_n;

	// result register
	logic       res_valid_q;
	cmd_t       cmd_q, cmd_n;
	logic [7:0] tx_q, tx_n;
	logic       rv_q, rv_n;
	logic [7:0] rb_q, rb_n;
	logic       done_q, done_n;
	logic [6:0] ddev_q, ddev_n;
	logic [7:0] dsub_q, dsub_n;
	status_t    st_q, st_n;
	logic       idle_out_q;

	logic             go;
	logic             hq_push, hq_pop, dq_push, dq_pop;
	logic             kick, bus_try, start_ok;
	logic             hq_full, dq_full, room_short;
	logic [7:0]       bc_inc;
	logic [7:0]       data_head;
	i2crts_pkg::hdr_t new_hdr, head_hdr;

	assign item_ready = !valid_s1;
	assign go = valid_s1 && (!res_valid_q || result_ready);

	assign new_hdr = '{dev: dev_s1, sub: sub_s1, is_read: rd_s1, len: len_s1};
	// an empty header queue can only be started from the header arriving now
	assign head_hdr = (hq_count == '0) ? new_hdr : i2crts_pkg::hdr_t'(hq_rdata);
	assign data_head = (dq_count != '0) ? dq_rdata : 8'd0;
	assign hq_full = hq_count == HC_W'(HEADER_DEPTH);
	assign dq_full = dq_count == DC_W'(DATA_DEPTH);
	assign room_short = (SUM_W'(dq_count) + SUM_W'(len_s1)) > SUM_W'(DATA_DEPTH);
	assign bc_inc = bc_q + 8'd1;

	always_comb begin
		phase_n = phase_q;
		idle_n = idle_q;
		hdr_n = hdr_q;
		bc_n = bc_q;
		wbp_n = wbp_q;
		hq_push = 1'b0;
		hq_pop = 1'b0;
		dq_push = 1'b0;
		dq_pop = 1'b0;
		kick = 1'b0;
		bus_try = 1'b0;
		start_ok = 1'b0;
		cmd_n = CMD_NONE;
		tx_n = '0;
		rv_n = 1'b0;
		rb_n = '0;
		done_n = 1'b0;
		ddev_n = '0;
		dsub_n = '0;
		st_n = ST_OK;
		case (func_s1)
			FN_HDR: begin
				if (wbp_q != '0) begin
					st_n = ST_IGNORED;
				end else if (hq_full || (!rd_s1 && room_short)) begin
					st_n = ST_DROPPED;
				end else begin
					hq_push = 1'b1;
					if (!rd_s1) begin
						wbp_n = len_s1;
					end
					kick = 1'b1;
				end
			end
			FN_DATA: begin
				if (wbp_q == '0 || dq_full) begin
					st_n = ST_IGNORED;
				end else begin
					dq_push = 1'b1;
					wbp_n = wbp_q - 8'd1;
					kick = 1'b1;
				end
			end
			FN_BUS: begin
				if (idle_q) begin
					st_n = ST_IGNORED;
				end else begin
					case (phase_q)
						PH_STARTED: begin
							cmd_n = CMD_TX;
							tx_n = {hdr_q.dev, 1'b0};
							bc_n = '0;
							phase_n = PH_ADDR_W;
						end
						PH_ADDR_W: begin
							cmd_n = CMD_TX;
							tx_n = hdr_q.sub;
							phase_n = PH_SUB;
						end
						PH_SUB: begin
							if (hdr_q.is_read) begin
								cmd_n = CMD_RESTART;
								phase_n = PH_RESTART;
							end else if (hdr_q.len != '0) begin
								cmd_n = CMD_TX;
								tx_n = data_head;
								dq_pop = dq_count != '0;
								phase_n = PH_DATA_TX;
							end else begin
								cmd_n = CMD_STOP;
								phase_n = PH_STOPPED;
							end
						end
						PH_DATA_TX: begin
							bc_n = bc_inc;
							if (bc_inc >= hdr_q.len) begin
								cmd_n = CMD_STOP;
								phase_n = PH_STOPPED;
							end else begin
								cmd_n = CMD_TX;
								tx_n = data_head;
								dq_pop = dq_count != '0;
							end
						end
						PH_RESTART: begin
							cmd_n = CMD_TX;
							tx_n = {hdr_q.dev, 1'b1};
							phase_n = PH_ADDR_R;
						end
						PH_ADDR_R, PH_ACK: begin
							cmd_n = CMD_RX;
							phase_n = PH_DATA_RX;
						end
						PH_DATA_RX: begin
							rv_n = 1'b1;
							rb_n = rb_s1;
							bc_n = bc_inc;
							if (bc_inc >= hdr_q.len) begin
								cmd_n = CMD_NACK;
								phase_n = PH_NACK;
							end else begin
								cmd_n = CMD_ACK;
								phase_n = PH_ACK;
							end
						end
						PH_NACK: begin
							cmd_n = CMD_STOP;
							done_n = 1'b1;
							ddev_n = hdr_q.dev;
							dsub_n = hdr_q.sub;
							phase_n = PH_STOPPED;
						end
						default: begin
							bus_try = 1'b1;
						end
					endcase
				end
			end
			default: begin
				st_n = ST_IGNORED;
			end
		endcase
		// next transaction is complete when it is followed by another header
		// or all of its write bytes are in
		if (hq_push) begin
			start_ok = (hq_count != '0) || (wbp_n == '0);
		end else begin
			start_ok = (hq_count > HC_W'(1)) || ((hq_count == HC_W'(1)) && (wbp_n == '0));
		end
		if (bus_try || (kick && idle_q && phase_q == PH_STOPPED)) begin
			if (start_ok) begin
				hq_pop = 1'b1;
				hdr_n = head_hdr;
				idle_n = 1'b0;
				phase_n = PH_STARTED;
				cmd_n = CMD_START;
			end else begin
				idle_n = 1'b1;
				phase_n = PH_STOPPED;
			end
		end
	end

	assign hq_ctl = '{push: hq_push && go, pop: hq_pop && go};
	assign dq_ctl = '{push: dq_push && go, pop: dq_pop && go};
	assign hq_wdata = new_hdr;
	assign dq_wdata = wb_s1;

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			func_s1 <= func;
			dev_s1 <= dev_addr;
			sub_s1 <= reg_addr;
			rd_s1 <= is_read;
			len_s1 <= length;
			wb_s1 <= write_byte;
			rb_s1 <= received_byte;
		end
		if (go) begin
			cmd_q <= cmd_n;
			tx_q <= tx_n;
			rv_q <= rv_n;
			rb_q <= rb_n;
			done_q <= done_n;
			ddev_q <= ddev_n;
			dsub_q <= dsub_n;
			st_q <= st_n;
			idle_out_q <= idle_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			phase_q <= PH_STOPPED;
			idle_q <= 1'b1;
			hdr_q <= '0;
			bc_q <= '0;
			wbp_q <= '0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (go) begin
				res_valid_q <= 1'b1;
				phase_q <= phase_n;
				idle_q <= idle_n;
				hdr_q <= hdr_n;
				bc_q <= bc_n;
				wbp_q <= wbp_n;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign bus_command = cmd_q;
	assign tx_byte = tx_q;
	assign read_valid = rv_q;
	assign read_byte = rb_q;
	assign read_done = done_q;
	assign done_dev_addr = ddev_q;
	assign done_reg_addr = dsub_q;
	assign status = st_q;
	assign bus_idle = idle_out_q;

endmodule

// ===== rtl/i2c_register_transaction_sequencer_unit.sv =====
// top level of the i2c register transaction sequencer
// Each accepted transaction yields exactly one result. A transaction is
// registered on acceptance while the header and data queue heads are read
// from their memories; a later edge, once the result register is free,
// commits the state update and loads the result register. A new transaction
// is not accepted until the held one has been committed. The result register
// lets the next transaction enter while a result waits to be taken. Both
// queues start empty after reset and need no clearing pass.
module i2c_register_transaction_sequencer_unit #(
	parameter int HEADER_DEPTH = i2crts_pkg::HEADER_DEPTH_DEF,
	parameter int DATA_DEPTH = i2crts_pkg::DATA_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] func,
	input  logic [6:0] dev_addr,
	input  logic [7:0] reg_addr,
	input  logic       is_read,
	input  logic [7:0] length,
	input  logic [7:0] write_byte,
	input  logic [7:0] received_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [2:0] bus_command,
	output logic [7:0] tx_byte,
	output logic       read_valid,
	output logic [7:0] read_byte,
	output logic       read_done,
	output logic [6:0] done_dev_addr,
	output logic [7:0] done_reg_addr,
	output logic [1:0] status,
	output logic       bus_idle
);

	localparam int HC_W = $clog2(HEADER_DEPTH + 1);
	localparam int DC_W = $clog2(DATA_DEPTH + 1);

	i2crts_pkg::q_ctl_t           hq_ctl;
	i2crts_pkg::q_ctl_t           dq_ctl;
	logic [i2crts_pkg::HDR_W-1:0] hq_wdata;
	logic [i2crts_pkg::HDR_W-1:0] hq_rdata;
	logic [HC_W-1:0]              hq_count;
	logic [7:0]                   dq_wdata;
	logic [7:0]                   dq_rdata;
	logic [DC_W-1:0]              dq_count;

	i2crts_queue #(
		.W(i2crts_pkg::HDR_W),
		.DEPTH(HEADER_DEPTH)
	) u_hdr_queue (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(hq_ctl),
		.wdata(hq_wdata),
		.rdata(hq_rdata),
		.count(hq_count)
	);

	i2crts_queue #(
		.W(8),
		.DEPTH(DATA_DEPTH)
	) u_data_queue (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(dq_ctl),
		.wdata(dq_wdata),
		.rdata(dq_rdata),
		.count(dq_count)
	);

	i2crts_seq #(
		.HEADER_DEPTH(HEADER_DEPTH),
		.DATA_DEPTH(DATA_DEPTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.func(func),
		.dev_addr(dev_addr),
		.reg_addr(reg_addr),
		.is_read(is_read),
		.length(length),
		.write_byte(write_byte),
		.received_byte(received_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.bus_command(bus_command),
		.tx_byte(tx_byte),
		.read_valid(read_valid),
		.read_byte(read_byte),
		.read_done(read_done),
		.done_dev_addr(done_dev_addr),
		.done_reg_addr(done_reg_addr),
		.status(status),
		.bus_idle(bus_idle),
		.hq_ctl(hq_ctl),
		.hq_wdata(hq_wdata),
		.hq_rdata(hq_rdata),
		.hq_count(hq_count),
		.dq_ctl(dq_ctl),
		.dq_wdata(dq_wdata),
		.dq_rdata(dq_rdata),
		.dq_count(dq_count)
	);

endmodule
